[rtl/linear_ramp_ring_fill_assert.svh]
// Assertion macros used by the checker of the ramp ring fill block.
`ifndef LINEAR_RAMP_RING_FILL_ASSERT_SVH
`define LINEAR_RAMP_RING_FILL_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LRRF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LRRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lrrf_pkg.sv]
// Types and constants of the ramp ring fill block.
`timescale 1ns / 1ps
package lrrf_pkg;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;
  localparam logic [7:0]  BYTE_MASK  = 8'hff;

  localparam logic CMD_RAMP  = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_DIV,
    ST_RAMP,
    ST_DONE
  } lrrf_state_e;

  typedef struct packed {
    logic        start;
    logic [7:0]  dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  quot;
    logic [15:0] rem;
  } div_res_t;

endpackage

[rtl/linear_ramp_ring_fill.sv]
// Top level of the ramp ring fill block: command sequencer around the buffer RAM.
// The buffer is one RAM with a registered read port and one write port. After reset a clearing
// pass writes zero to every entry, with no command taken. A command is then taken only in idle
// and runs alone. A read_address or start_position beyond the buffer is first reduced by
// repeated subtraction of BUFFER_DEPTH. A ramp of count n writes one byte per cycle through the
// single write port after an 8-step division of the level difference by n; a zero count writes
// nothing and is only acknowledged. The result
// sits in an output register, so the next command is taken while it waits for the sink.
`timescale 1ns / 1ps
module linear_ramp_ring_fill #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_position[7:0], sample_count[23:8], start_level[31:24], end_level[39:32],
  // read_address[47:40]
  input  logic [lrrf_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // command[0]
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // read_data[7:0]
  output logic [lrrf_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // result_kind[0]
  output logic                               m_axis_tuser_o
);

  import lrrf_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_DEPTH - 1);

  lrrf_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          m_valid_q, m_valid_d;
  logic          m_kind_q, m_kind_d;
  logic [7:0]    m_data_q, m_data_d;

  logic          cmd_q, cmd_d;
  logic [7:0]    from_q, from_d;
  logic          neg_q, neg_d;
  logic [7:0]    mag_q, mag_d;
  logic [15:0]   n_q, n_d;
  logic [7:0]    red_q, red_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [15:0]   left_q, left_d;
  logic [7:0]    qd_q, qd_d;
  logic [15:0]   rd_q, rd_d;
  logic [7:0]    qacc_q, qacc_d;
  logic [15:0]   racc_q, racc_d;

  logic [7:0]    s_start, s_from, s_to, s_raddr;
  logic [15:0]   s_count;
  logic [16:0]   racc_sum;
  logic          racc_wrap;
  logic [7:0]    level;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  div_req_t div_req;
  div_res_t div_res;

  assign s_start = s_axis_tdata_i[7:0];
  assign s_count = s_axis_tdata_i[23:8];
  assign s_from  = s_axis_tdata_i[31:24];
  assign s_to    = s_axis_tdata_i[39:32];
  assign s_raddr = s_axis_tdata_i[47:40];

  assign racc_sum  = {1'b0, racc_q} + {1'b0, rd_q};
  assign racc_wrap = racc_sum >= {1'b0, n_q};
  assign level     = (neg_q ? (from_q - qacc_q) : (from_q + qacc_q)) & BYTE_MASK;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    m_valid_d = m_valid_q;
    m_kind_d  = m_kind_q;
    m_data_d  = m_data_q;
    cmd_d     = cmd_q;
    from_d    = from_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    n_d       = n_q;
    red_d     = red_q;
    pos_d     = pos_q;
    left_d    = left_q;
    qd_d      = qd_q;
    rd_d      = rd_q;
    qacc_d    = qacc_q;
    racc_d    = racc_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = level;
    ram_re    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag_q;
    div_req.divisor  = n_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_POS) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = s_axis_tuser_i;
          from_d  = s_from;
          neg_d   = s_to < s_from;
          mag_d   = (s_to < s_from) ? (s_from - s_to) : (s_to - s_from);
          n_d     = s_count;
          red_d   = (s_axis_tuser_i == CMD_READ) ? s_raddr : s_start;
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_q >= BUFFER_DEPTH) begin
          red_d = red_q - 8'(BUFFER_DEPTH);
        end else if (cmd_q == CMD_READ) begin
          ram_re  = 1'b1;
          state_d = ST_DONE;
        end else if (n_q == '0) begin
          state_d = ST_DONE;
        end else begin
          pos_d         = AW'(red_q);
          left_d        = n_q;
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          qd_d    = div_res.quot;
          rd_d    = div_res.rem;
          qacc_d  = div_res.quot;
          racc_d  = div_res.rem;
          state_d = ST_RAMP;
        end
      end
      ST_RAMP: begin
        ram_we = 1'b1;
        pos_d  = (pos_q == LAST_POS) ? '0 : pos_q + AW'(1);
        racc_d = racc_wrap ? 16'(racc_sum - {1'b0, n_q}) : racc_sum[15:0];
        qacc_d = qacc_q + qd_q + {7'b0, racc_wrap};
        left_d = left_q - 16'd1;
        if (left_q == 16'd1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_kind_d  = (cmd_q == CMD_READ) ? KIND_DATA : KIND_ACK;
          m_data_d  = (cmd_q == CMD_READ) ? ram_rdata : '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_kind_q <= m_kind_d;
    m_data_q <= m_data_d;
    cmd_q    <= cmd_d;
    from_q   <= from_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    n_q      <= n_d;
    red_q    <= red_d;
    pos_q    <= pos_d;
    left_q   <= left_d;
    qd_q     <= qd_d;
    rd_q     <= rd_d;
    qacc_q   <= qacc_d;
    racc_q   <= racc_d;
  end

  lrrf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  lrrf_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(red_q)),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_kind_q;

endmodule

[rtl/lrrf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module lrrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lrrf_div.sv]
// Restoring divider, one quotient bit per cycle, for the ramp step size.
`timescale 1ns / 1ps
module lrrf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrrf_pkg::div_req_t  req_i,
  output lrrf_pkg::div_res_t  res_o
);

  import lrrf_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  step_q, step_d;
  logic [7:0]  dvd_q, dvd_d;
  logic [15:0] dvs_q, dvs_d;
  logic [7:0]  quot_q, quot_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_q, dvd_q[7]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quot_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      quot_d = {quot_q[6:0], fits};
      dvd_d  = {dvd_q[6:0], 1'b0};
      step_d = step_q + 3'd1;
      if (step_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

[rtl/lrrf_chk.sv]
// Port-level checker of the ramp ring fill block, bound to the top level.
`timescale 1ns / 1ps
`include "linear_ramp_ring_fill_assert.svh"
module lrrf_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [lrrf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);

  import lrrf_pkg::*;

  logic       in_beat, out_beat;
  logic [1:0] pend_q, pend_d;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    pend_d = pend_q + {1'b0, in_beat} - {1'b0, out_beat};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `LRRF_ASSERT_NEXT(m_hold_a, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result beat changed")
  `LRRF_ASSERT_IMPL(ack_zero_a, m_axis_tvalid_o && (m_axis_tuser_o == KIND_ACK), m_axis_tdata_o == '0, "ramp acknowledge with nonzero data")
  `LRRF_ASSERT_IMPL(out_owed_a, m_axis_tvalid_o, pend_q != 2'd0, "result beat without a command")
  `LRRF_ASSERT_IMPL(pend_bound_a, 1'b1, pend_q != 2'd3, "more than two commands in flight")

endmodule

bind linear_ramp_ring_fill lrrf_chk u_lrrf_chk (.*);
